// ===== design/clps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clps_pkg
// Shared constants and types for the change-logging pin sampler.
// ----------------------------------------------------------------------------
package clps_pkg;

	localparam int STORE_DEPTH_DEF = 4096;
	localparam int CHANNELS_DEF    = 8;

	localparam int REQ_W    = 2;
	localparam int LEVEL_W  = 8;
	localparam int COUNT_W  = 32;

	// Request kinds carried in the input tuser field.
	localparam logic [REQ_W-1:0] REQ_START = 2'd0;
	localparam logic [REQ_W-1:0] REQ_TICK  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

	// One logged change: sample number and pin levels.
	typedef struct packed {
		logic [COUNT_W-1:0] sample;
		logic [LEVEL_W-1:0] levels;
	} entry_t;

	localparam int ENTRY_W = COUNT_W + LEVEL_W;

endpackage

// ===== design/change_logging_pin_sampler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// change_logging_pin_sampler_top
// Logs pin level changes into a ring store and reads them back by cursor.
//
//   channel  | direction | tuser              | tdata
//   s_axis   | in        | req_type           | pins, cursor
//   m_axis   | out       | event_valid        | event_sample, event_levels,
//            |           |                    | next_cursor, current_levels,
//            |           |                    | write_position, sample_count
//
// One item is taken per cycle while m_axis does not stall; its result leaves
// the output register behind the fourth stage. Counters update at the input
// transfer, while the store is read or written only as the item enters the
// fourth stage, after the cursor or the write count is reduced modulo the
// store depth by a reciprocal multiply, so store accesses keep item order.
// Reset clears the counters and the pipeline valids; the store is not
// cleared. A stall at m_axis fills the stages before s_tready drops.
// ----------------------------------------------------------------------------
module change_logging_pin_sampler_top #(
	parameter int STORE_DEPTH = clps_pkg::STORE_DEPTH_DEF,
	parameter int CHANNELS    = clps_pkg::CHANNELS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [1:0]   s_axis_tuser,   // [1:0] req_type
	input  logic [39:0]  s_axis_tdata,   // [7:0] pins, [39:8] cursor
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [0:0]   m_axis_tuser,   // [0] event_valid
	// [31:0] event_sample, [39:32] event_levels, [71:40] next_cursor,
	// [79:72] current_levels, [111:80] write_position, [143:112] sample_count
	output logic [143:0] m_axis_tdata
);

	localparam int AddrW = $clog2(STORE_DEPTH);
	localparam int CntW  = clps_pkg::COUNT_W;
	localparam int LvlW  = clps_pkg::LEVEL_W;

	localparam logic [LvlW-1:0] LvlMask = (CHANNELS >= LvlW) ? {LvlW{1'b1}} :
		LvlW'((9'd1 << CHANNELS) - 9'd1);

	// floor(2^(32+AddrW) / depth): the quotient estimate is low by at most one.
	localparam logic [32:0] RecipK = 33'((65'd1 << (CntW + AddrW)) / 65'(STORE_DEPTH));
	localparam logic [16:0] DepthK = 17'(STORE_DEPTH);
	localparam logic [AddrW:0] DepthR = (AddrW+1)'(STORE_DEPTH);
	localparam logic [AddrW-1:0] LastAddr = AddrW'(STORE_DEPTH - 1);

	typedef struct packed {
		logic                 wr;
		logic                 rd;
		logic [CntW-1:0]      cursor;
		clps_pkg::entry_t     wdata;
		logic [LvlW-1:0]      levels;
		logic [CntW-1:0]      wpos;
		logic [CntW-1:0]      scount;
	} item_t;

	// Architectural state.
	logic [CntW-1:0]  wcount_q, tcount_q;
	logic [LvlW-1:0]  last_q;

	// Pipeline.
	logic             v1_s1, v2_s2, v3_s3, v4_s4, out_v_q;
	item_t            item_s1, item_s2, item_s3, item_s4;
	logic [CntW-1:0]  mod_s1, mod_s2;
	logic [48:0]      pp_lo_s1;
	logic [47:0]      pp_hi_s1;
	logic [CntW-1:0]  quo_s2;
	logic [AddrW:0]   rem_s3;
	logic [0:0]       out_user_q;
	logic [143:0]     out_data_q;

	logic c1, c2, c3, c4, c_out, acc;
	logic [1:0]       req;
	logic [LvlW-1:0]  pins_m;
	logic [CntW-1:0]  cur;
	logic             chg;
	logic [CntW-1:0]  mod_in;
	item_t            item_in;
	logic [64:0]      prod_sum;
	logic [48:0]      qd_full;
	logic [AddrW-1:0] raddr;
	logic             mem_we, mem_re;
	logic [AddrW-1:0] mem_addr;
	clps_pkg::entry_t rdata;

	assign c_out = !out_v_q || m_axis_tready;
	assign c4    = !v4_s4 || c_out;
	assign c3    = !v3_s3 || c4;
	assign c2    = !v2_s2 || c3;
	assign c1    = !v1_s1 || c2;
	assign s_axis_tready = c1;
	assign acc   = s_axis_tvalid && c1;

	assign req    = s_axis_tuser;
	assign pins_m = s_axis_tdata[7:0] & LvlMask;
	assign cur    = s_axis_tdata[39:8];
	assign chg    = (req == clps_pkg::REQ_TICK) && (pins_m != last_q);

	// A logged change is stored at the write count, a read at its cursor.
	assign mod_in = chg ? wcount_q : cur;

	always_comb begin
		item_in        = '0;
		item_in.cursor = cur;
		item_in.wr     = chg;
		item_in.rd     = (req == clps_pkg::REQ_READ) && (cur != wcount_q);
		item_in.wdata.sample = tcount_q;
		item_in.wdata.levels = pins_m;
		item_in.levels = last_q;
		item_in.wpos   = wcount_q;
		item_in.scount = tcount_q;
		case (req)
			clps_pkg::REQ_START: begin
				item_in.levels = pins_m;
				item_in.wpos   = '0;
				item_in.scount = '0;
			end
			clps_pkg::REQ_TICK: begin
				if (chg) begin
					item_in.levels = pins_m;
					item_in.wpos   = wcount_q + 1'b1;
				end
				item_in.scount = tcount_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcount_q <= '0;
			tcount_q <= '0;
			last_q   <= '0;
		end else if (acc) begin
			wcount_q <= item_in.wpos;
			tcount_q <= item_in.scount;
			last_q   <= item_in.levels;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1   <= 1'b0;
			v2_s2   <= 1'b0;
			v3_s3   <= 1'b0;
			v4_s4   <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (c1)    v1_s1   <= s_axis_tvalid;
			if (c2)    v2_s2   <= v1_s1;
			if (c3)    v3_s3   <= v2_s2;
			if (c4)    v4_s4   <= v3_s3;
			if (c_out) out_v_q <= v4_s4;
		end
	end

	// Store address modulo depth: split reciprocal product, quotient, remainder.
	assign prod_sum = 65'(pp_lo_s1) + (65'(pp_hi_s1) << 17);
	assign qd_full  = 49'(quo_s2) * 49'(DepthK);
	assign raddr    = (rem_s3 >= DepthR) ? AddrW'(rem_s3 - DepthR) : AddrW'(rem_s3);

	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1  <= item_in;
			mod_s1   <= mod_in;
			pp_lo_s1 <= 49'(mod_in) * 49'(RecipK[16:0]);
			pp_hi_s1 <= 48'(mod_in) * 48'(RecipK[32:17]);
		end
		if (c2 && v1_s1) begin
			item_s2  <= item_s1;
			mod_s2   <= mod_s1;
			quo_s2   <= CntW'(prod_sum >> (CntW + AddrW));
		end
		if (c3 && v2_s2) begin
			item_s3  <= item_s2;
			rem_s3   <= (AddrW+1)'(mod_s2 - qd_full[CntW-1:0]);
		end
		if (c4 && v3_s3) begin
			item_s4 <= item_s3;
		end
		if (c_out && v4_s4) begin
			out_user_q <= item_s4.rd;
			out_data_q <= {item_s4.scount, item_s4.wpos, item_s4.levels,
				item_s4.rd ? item_s4.cursor + 1'b1 : item_s4.cursor,
				item_s4.rd ? {rdata.levels, rdata.sample} : '0};
		end
	end

	// All store accesses happen as items enter the fourth stage, in item order.
	assign mem_we   = c4 && v3_s3 && item_s3.wr;
	assign mem_re   = c4 && v3_s3 && item_s3.rd;
	assign mem_addr = raddr;

	clps_store #(
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (item_s3.wdata),
		.rdata (rdata)
	);

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tdata  = out_data_q;

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req == clps_pkg::REQ_START |=> wcount_q == '0 && tcount_q == '0)
		else $error("start transfer did not clear the counters");

	a_tick_counts: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req == clps_pkg::REQ_TICK |=> tcount_q == $past(tcount_q) + 1'b1)
		else $error("tick transfer did not advance the sample count");

	a_read_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> raddr <= LastAddr)
		else $error("reduced cursor address out of range");

	a_no_event_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[39:0] == '0)
		else $error("event fields not zero on a result without event");

endmodule

// ===== design/clps_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clps_store
// Single-port event store with a registered read port.
// ----------------------------------------------------------------------------
module clps_store #(
	parameter int DEPTH = clps_pkg::STORE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  clps_pkg::entry_t         wdata,
	output clps_pkg::entry_t         rdata
);

	clps_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule
